### rtl/core/lgs_pkg.sv
// lgs_pkg: shared types and constants for the life grid generation step block
// no dependencies; used by lgs_ctrl, lgs_dpath and the top level
package lgs_pkg;

  localparam int CFG_W        = 6;
  localparam int INDEX_W      = 10;
  localparam int SIDE_RESET   = 32;
  localparam int BIRTH_COUNT  = 3;
  localparam int SURVIVE_LOW  = 2;
  localparam int SURVIVE_HIGH = 3;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] cell_index;
    logic               cell_alive_in;
  } in_item_t;

  typedef struct packed {
    logic cell_alive_out;
    logic unchanged;
  } out_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_LAT,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WSRC_ZERO,
    WSRC_ITEM,
    WSRC_NEW
  } wsrc_t;

  typedef struct packed {
    logic  mem_we;
    wsrc_t wsrc;
    logic  ld_en;
    logic  init;
    logic  row_shift;
    logic  compute;
    logic  sr_shift;
    logic  rsp_read;
    logic  rsp_adv;
  } cmd_t;

endpackage

### rtl/core/lgs_ram.sv
// lgs_ram: generic single write port, single read port ram with registered read
// no dependencies
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lgs_dpath.sv
// lgs_dpath: cell ram, three row buffers, per-column rule lanes, write-back shifter
// depends on lgs_pkg and lgs_ram
module lgs_dpath #(
  parameter int MAX_SIDE = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lgs_pkg::cmd_t                         cmd,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  waddr,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  raddr,
  input  logic [$clog2(MAX_SIDE)-1:0]           ld_col,
  input  logic [$clog2(MAX_SIDE+1)-1:0]         side,
  input  logic                                  item_alive,
  output lgs_pkg::out_result_t                  out_result
);

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int COL_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  logic                rdata;
  logic                wdata;
  logic [MAX_SIDE-1:0] up_r, mid_r, dn_r;
  logic [MAX_SIDE-1:0] up_nxt, mid_nxt, dn_nxt;
  logic [MAX_SIDE-1:0] sr_r, sr_nxt;
  logic                changed_r, changed_nxt;
  logic                ld_en_r;
  logic [COL_W-1:0]    ld_col_r;
  logic                rsp_read_r, rsp_adv_r;
  logic [MAX_SIDE+1:0] up_p, mid_p, dn_p;
  logic [3:0]          cnt [MAX_SIDE];
  logic [MAX_SIDE-1:0] mask;
  logic [MAX_SIDE-1:0] new_row;

  always_comb begin
    unique case (cmd.wsrc)
      lgs_pkg::WSRC_ZERO: wdata = 1'b0;
      lgs_pkg::WSRC_ITEM: wdata = item_alive;
      lgs_pkg::WSRC_NEW:  wdata = sr_r[0];
      default:            wdata = 1'b0;
    endcase
  end

  lgs_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rule lanes, one per column; cells outside the grid are zero
  always_comb begin
    up_p  = {1'b0, up_r, 1'b0};
    mid_p = {1'b0, mid_r, 1'b0};
    dn_p  = {1'b0, dn_r, 1'b0};
    for (int j = 0; j < MAX_SIDE; j++) begin
      cnt[j] = 4'(up_p[j]) + 4'(up_p[j+1]) + 4'(up_p[j+2])
             + 4'(mid_p[j]) + 4'(mid_p[j+2])
             + 4'(dn_p[j]) + 4'(dn_p[j+1]) + 4'(dn_p[j+2]);
      mask[j] = (SIDE_W'(j) < side);
      if (mid_r[j]) begin
        new_row[j] = mask[j] && (cnt[j] >= 4'(lgs_pkg::SURVIVE_LOW))
                             && (cnt[j] <= 4'(lgs_pkg::SURVIVE_HIGH));
      end else begin
        new_row[j] = mask[j] && (cnt[j] == 4'(lgs_pkg::BIRTH_COUNT));
      end
    end
  end

  always_comb begin
    up_nxt      = up_r;
    mid_nxt     = mid_r;
    dn_nxt      = dn_r;
    sr_nxt      = sr_r;
    changed_nxt = changed_r;
    if (cmd.init) begin
      up_nxt      = '0;
      mid_nxt     = '0;
      dn_nxt      = '0;
      changed_nxt = 1'b0;
    end else begin
      if (ld_en_r) begin
        dn_nxt[ld_col_r] = rdata;
      end
      if (cmd.compute) begin
        sr_nxt      = new_row;
        changed_nxt = changed_r | (|((new_row ^ mid_r) & mask));
      end else if (cmd.sr_shift) begin
        sr_nxt = sr_r >> 1;
      end
      if (cmd.row_shift) begin
        up_nxt  = mid_r;
        mid_nxt = dn_r;
        dn_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r  <= 1'b0;
      ld_en_r    <= 1'b0;
      rsp_read_r <= 1'b0;
      rsp_adv_r  <= 1'b0;
    end else begin
      changed_r  <= changed_nxt;
      ld_en_r    <= cmd.ld_en;
      rsp_read_r <= cmd.rsp_read;
      rsp_adv_r  <= cmd.rsp_adv;
    end
  end

  always_ff @(posedge clk) begin
    up_r     <= up_nxt;
    mid_r    <= mid_nxt;
    dn_r     <= dn_nxt;
    sr_r     <= sr_nxt;
    ld_col_r <= ld_col;
  end

  assign out_result.cell_alive_out = rsp_read_r & rdata;
  assign out_result.unchanged      = rsp_adv_r & ~changed_r;

endmodule

### rtl/core/lgs_ctrl.sv
// lgs_ctrl: control state machine, side register, row/column counters, address generation
// depends on lgs_pkg
module lgs_ctrl #(
  parameter int MAX_SIDE = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  lgs_pkg::in_item_t                     in_item,
  input  logic                                  cfg_we,
  input  logic [lgs_pkg::CFG_W-1:0]             cfg_wdata,
  output logic                                  out_strobe,
  output lgs_pkg::cmd_t                         cmd,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  waddr,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  raddr,
  output logic [$clog2(MAX_SIDE)-1:0]           ld_col,
  output logic [$clog2(MAX_SIDE+1)-1:0]         side
);

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int K_W    = $clog2(MAX_SIDE + 2);
  localparam int BASE_W = $clog2(MAX_SIDE * (MAX_SIDE + 1) + 1);
  localparam int TOT_W  = 2 * SIDE_W;
  localparam int CMP_W  = (TOT_W > lgs_pkg::INDEX_W) ? TOT_W : lgs_pkg::INDEX_W;
  localparam int CFGC_W = (SIDE_W > lgs_pkg::CFG_W) ? SIDE_W : lgs_pkg::CFG_W;

  lgs_pkg::state_t           state_r, state_nxt;
  logic [lgs_pkg::CFG_W-1:0] cfg_side_r;
  logic [K_W-1:0]            k_r, k_nxt;
  logic [COL_W-1:0]          c_r, c_nxt;
  logic [BASE_W-1:0]         rd_base_r, rd_base_nxt;
  logic [BASE_W-1:0]         mid_base_r, mid_base_nxt;
  logic [BASE_W-1:0]         wr_base_r, wr_base_nxt;
  logic [ADDR_W-1:0]         clr_r, clr_nxt;
  logic                      strobe_r, strobe_nxt;
  logic [TOT_W-1:0]          total;
  logic                      in_range;
  logic                      accept;
  logic                      last_col;
  logic [K_W-1:0]            side_k;

  always_comb begin
    if (cfg_side_r == '0) begin
      side = SIDE_W'(1);
    end else if (CFGC_W'(cfg_side_r) > CFGC_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(cfg_side_r);
    end
  end

  assign total    = TOT_W'(side) * TOT_W'(side);
  assign in_range = CMP_W'(in_item.cell_index) < CMP_W'(total);
  assign busy     = (state_r != lgs_pkg::ST_IDLE);
  assign accept   = start & ~busy;
  assign last_col = (c_r == COL_W'(side - SIDE_W'(1)));
  assign side_k   = K_W'(side);
  assign ld_col   = c_r;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    c_nxt        = c_r;
    rd_base_nxt  = rd_base_r;
    mid_base_nxt = mid_base_r;
    wr_base_nxt  = wr_base_r;
    clr_nxt      = clr_r;
    strobe_nxt   = 1'b0;
    cmd          = '0;
    cmd.wsrc     = lgs_pkg::WSRC_ZERO;
    waddr        = ADDR_W'(BASE_W'(wr_base_r) + BASE_W'(c_r));
    raddr        = ADDR_W'(BASE_W'(rd_base_r) + BASE_W'(c_r));
    unique case (state_r)
      lgs_pkg::ST_CLEAR: begin
        cmd.mem_we = 1'b1;
        waddr      = clr_r;
        clr_nxt    = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = lgs_pkg::ST_IDLE;
        end
      end
      lgs_pkg::ST_IDLE: begin
        waddr = ADDR_W'(in_item.cell_index);
        raddr = ADDR_W'(in_item.cell_index);
        if (accept) begin
          unique case (in_item.op)
            lgs_pkg::OP_WRITE: begin
              cmd.mem_we = in_range;
              cmd.wsrc   = lgs_pkg::WSRC_ITEM;
              strobe_nxt = 1'b1;
            end
            lgs_pkg::OP_READ: begin
              cmd.rsp_read = in_range;
              strobe_nxt   = 1'b1;
            end
            lgs_pkg::OP_ADVANCE: begin
              cmd.init    = 1'b1;
              k_nxt       = '0;
              c_nxt       = '0;
              rd_base_nxt = '0;
              state_nxt   = lgs_pkg::ST_LOAD;
            end
            lgs_pkg::OP_NONE: begin
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      lgs_pkg::ST_LOAD: begin
        // read row k into the bottom buffer, write back new row k-2
        cmd.ld_en    = (k_r < side_k);
        cmd.mem_we   = (k_r >= K_W'(2));
        cmd.wsrc     = lgs_pkg::WSRC_NEW;
        cmd.sr_shift = 1'b1;
        c_nxt        = c_r + COL_W'(1);
        if (last_col) begin
          c_nxt = '0;
          if (k_r == side_k + K_W'(1)) begin
            state_nxt = lgs_pkg::ST_DONE;
          end else begin
            state_nxt = lgs_pkg::ST_LAT;
          end
        end
      end
      lgs_pkg::ST_LAT: begin
        state_nxt = lgs_pkg::ST_CALC;
      end
      lgs_pkg::ST_CALC: begin
        cmd.compute   = (k_r >= K_W'(1)) && (k_r <= side_k);
        cmd.row_shift = 1'b1;
        k_nxt         = k_r + K_W'(1);
        wr_base_nxt   = mid_base_r;
        mid_base_nxt  = rd_base_r;
        rd_base_nxt   = rd_base_r + BASE_W'(side);
        state_nxt     = lgs_pkg::ST_LOAD;
      end
      lgs_pkg::ST_DONE: begin
        cmd.rsp_adv = 1'b1;
        strobe_nxt  = 1'b1;
        state_nxt   = lgs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lgs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lgs_pkg::ST_CLEAR;
      cfg_side_r <= lgs_pkg::CFG_W'(lgs_pkg::SIDE_RESET);
      k_r        <= '0;
      c_r        <= '0;
      clr_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      c_r      <= c_nxt;
      clr_r    <= clr_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        cfg_side_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_base_r  <= rd_base_nxt;
    mid_base_r <= mid_base_nxt;
    wr_base_r  <= wr_base_nxt;
  end

  assign out_strobe = strobe_r;

endmodule

### rtl/core/life_grid_generation_step_top.sv
// life_grid_generation_step_top: b3/s23 life grid with cell write, cell read and advance
// depends on lgs_pkg, lgs_ctrl, lgs_dpath (and lgs_ram below it)
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   input    | start, busy         | in_item   (op, cell_index, cell_alive_in)
//   result   | out_strobe          | out_result (cell_alive_out, unchanged)
//   config   | cfg_we              | cfg_wdata (grid_side)
//
// write, read and idle ops: result strobed the next cycle, busy stays low
// advance: busy through the row sweeps (LOAD, with LAT and CALC between sweeps, then DONE), paced
//   by the single read and write port of the cell ram: each sweep reads row k and writes back new row k-2
// after reset a clearing pass writes every cell dead, with busy high throughout the pass
// each result is a single-cycle transfer; the receiver cannot stall it
module life_grid_generation_step_top #(
  parameter int MAX_SIDE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lgs_pkg::in_item_t             in_item,
  input  logic                          cfg_we,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_strobe,
  output lgs_pkg::out_result_t          out_result
);

  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int COL_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  lgs_pkg::cmd_t     cmd;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [COL_W-1:0]  ld_col;
  logic [SIDE_W-1:0] side;

  lgs_ctrl #(
    .MAX_SIDE (MAX_SIDE)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .waddr      (waddr),
    .raddr      (raddr),
    .ld_col     (ld_col),
    .side       (side)
  );

  lgs_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .waddr      (waddr),
    .raddr      (raddr),
    .ld_col     (ld_col),
    .side       (side),
    .item_alive (in_item.cell_alive_in),
    .out_result (out_result)
  );

endmodule

### sim/life_grid_generation_step_top_tb.sv
// life_grid_generation_step_top_tb: self-checking testbench for the b3/s23 life grid block
// depends on lgs_pkg and life_grid_generation_step_top; predicts every result from its own
// copy of the grid and side register and checks each strobed transfer in order
`timescale 1ns / 100ps

module life_grid_generation_step_top_tb;

  localparam int MAX_SIDE     = 32;
  localparam int CELLS        = MAX_SIDE * MAX_SIDE;
  localparam int SETTLE_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  lgs_pkg::in_item_t         in_item;
  logic                      cfg_we;
  logic [lgs_pkg::CFG_W-1:0] cfg_wdata;
  logic                      out_strobe;
  lgs_pkg::out_result_t      out_result;

  life_grid_generation_step_top #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  // predictor state
  logic [CELLS-1:0]          life_cells;
  logic [lgs_pkg::CFG_W-1:0] grid_side_cfg;

  lgs_pkg::in_item_t    op_queue[$];
  lgs_pkg::out_result_t predicted_results[$];

  int     fail_count;
  int     n_writes;
  int     n_reads;
  int     n_advances;
  int     n_idle_ops;
  int     n_still;
  int     n_checked;
  int     n_sides;
  int     hold_off;
  bit     steady;
  longint cycle_count;

  always #2 clk = ~clk;

  function automatic int used_side(logic [lgs_pkg::CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return int'(s);
  endfunction

  task automatic step_generation(output logic same);
    int s, total, i, r, c, dr, dc, rr, cc, n;
    logic [CELLS-1:0] nxt;
    s = used_side(grid_side_cfg);
    total = s * s;
    nxt = life_cells;
    same = 1'b1;
    for (i = 0; i < total; i++) begin
      r = i / s;
      c = i % s;
      n = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (!(dr == 0 && dc == 0) && rr >= 0 && cc >= 0 && rr < s && cc < s)
            n += int'(life_cells[rr * s + cc]);
        end
      end
      if (life_cells[i]) begin
        nxt[i] = (n >= lgs_pkg::SURVIVE_LOW && n <= lgs_pkg::SURVIVE_HIGH);
      end else begin
        nxt[i] = (n == lgs_pkg::BIRTH_COUNT);
      end
      if (nxt[i] != life_cells[i]) same = 1'b0;
    end
    life_cells = nxt;
  endtask

  task automatic apply_life_op(input lgs_pkg::in_item_t item);
    lgs_pkg::out_result_t res;
    int total;
    logic same;
    res = '0;
    total = used_side(grid_side_cfg) * used_side(grid_side_cfg);
    case (item.op)
      lgs_pkg::OP_WRITE: begin
        n_writes++;
        if (int'(item.cell_index) < total) life_cells[item.cell_index] = item.cell_alive_in;
      end
      lgs_pkg::OP_READ: begin
        n_reads++;
        if (int'(item.cell_index) < total) res.cell_alive_out = life_cells[item.cell_index];
      end
      lgs_pkg::OP_ADVANCE: begin
        n_advances++;
        step_generation(same);
        res.unchanged = same;
        if (same) n_still++;
      end
      default: begin
        n_idle_ops++;
      end
    endcase
    predicted_results = {predicted_results, res};
  endtask

  function automatic int gap_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic [lgs_pkg::INDEX_W-1:0] pick_index(int total);
    int p;
    p = $urandom_range(0, 99);
    if (p >= 95) return lgs_pkg::INDEX_W'($urandom);
    if (p < 85 || total >= CELLS) return lgs_pkg::INDEX_W'($urandom_range(0, total - 1));
    return lgs_pkg::INDEX_W'($urandom_range(total, CELLS - 1));
  endfunction

  task automatic queue_op(input lgs_pkg::op_t op, input int idx, input logic alive);
    lgs_pkg::in_item_t item;
    item.op = op;
    item.cell_index = lgs_pkg::INDEX_W'(idx);
    item.cell_alive_in = alive;
    op_queue = {op_queue, item};
  endtask

  task automatic queue_random_phase(input int count, input bit wide);
    lgs_pkg::in_item_t item;
    int k, p, total;
    total = used_side(grid_side_cfg) * used_side(grid_side_cfg);
    for (k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        item.op = lgs_pkg::OP_WRITE;
      end else if (p < (wide ? 88 : 75)) begin
        item.op = lgs_pkg::OP_READ;
      end else if (p < (wide ? 95 : 92)) begin
        item.op = lgs_pkg::OP_ADVANCE;
      end else begin
        item.op = lgs_pkg::OP_NONE;
      end
      item.cell_index = pick_index(total);
      if (item.op == lgs_pkg::OP_WRITE) begin
        item.cell_alive_in = ($urandom_range(0, 99) < 60);
      end else begin
        item.cell_alive_in = 1'($urandom);
      end
      op_queue = {op_queue, item};
    end
  endtask

  // sender pauses here until every expected result has come back
  task automatic drain_block();
    while (op_queue.size() != 0 || predicted_results.size() != 0 || start)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_grid_side(input logic [lgs_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_side_cfg = v;
    n_sides++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_life_op(in_item);
        hold_off = gap_cycles();
      end
      if (!start || !busy) begin
        if (hold_off > 0) begin
          hold_off--;
          start <= 1'b0;
        end else if (op_queue.size() != 0) begin
          in_item <= op_queue.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lgs_pkg::out_result_t exp_res;
    if (rst_n && out_strobe) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no expectation: cell_alive_out=%0b unchanged=%0b",
               out_result.cell_alive_out, out_result.unchanged);
        fail_count++;
      end else begin
        exp_res = predicted_results.pop_front();
        n_checked++;
        if (out_result.cell_alive_out !== exp_res.cell_alive_out) begin
          $error("cell_alive_out: expected %0b actual %0b",
                 exp_res.cell_alive_out, out_result.cell_alive_out);
          fail_count++;
        end
        if (out_result.unchanged !== exp_res.unchanged) begin
          $error("unchanged: expected %0b actual %0b", exp_res.unchanged, out_result.unchanged);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("life_grid_generation_step_top regression: fail");
      $finish;
    end
  end

  initial begin
    int side_plan[15];
    int ph;
    int s;
    side_plan = '{5, 1, 2, 8, 63, 4, 6, 33, 7, 3, 10, 32, 16, 0, 5};
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    life_cells = '0;
    grid_side_cfg = lgs_pkg::CFG_W'(lgs_pkg::SIDE_RESET);
    fail_count = 0;
    n_writes = 0;
    n_reads = 0;
    n_advances = 0;
    n_idle_ops = 0;
    n_still = 0;
    n_checked = 0;
    n_sides = 0;
    hold_off = 0;
    steady = 1'b0;
    cycle_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // full grid after reset: corner cells, idle op, lone cells dying, still life
    queue_op(lgs_pkg::OP_READ, CELLS - 1, 1'b0);
    queue_op(lgs_pkg::OP_WRITE, CELLS - 1, 1'b1);
    queue_op(lgs_pkg::OP_READ, CELLS - 1, 1'b1);
    queue_op(lgs_pkg::OP_NONE, CELLS - 1, 1'b1);
    queue_op(lgs_pkg::OP_WRITE, 0, 1'b1);
    queue_op(lgs_pkg::OP_READ, 0, 1'b0);
    queue_op(lgs_pkg::OP_ADVANCE, 0, 1'b0);
    queue_op(lgs_pkg::OP_ADVANCE, 0, 1'b0);
    queue_op(lgs_pkg::OP_READ, 0, 1'b0);
    drain_block();

    // side 0 acts as one cell; out of range write and read
    write_grid_side('0);
    queue_op(lgs_pkg::OP_WRITE, 0, 1'b1);
    queue_op(lgs_pkg::OP_WRITE, CELLS - 1, 1'b1);
    queue_op(lgs_pkg::OP_READ, CELLS - 1, 1'b0);
    queue_op(lgs_pkg::OP_READ, 0, 1'b0);
    queue_op(lgs_pkg::OP_ADVANCE, 0, 1'b0);
    drain_block();

    // blinker on a 3x3 grid
    write_grid_side(lgs_pkg::CFG_W'(3));
    queue_op(lgs_pkg::OP_WRITE, 3, 1'b1);
    queue_op(lgs_pkg::OP_WRITE, 4, 1'b1);
    queue_op(lgs_pkg::OP_WRITE, 5, 1'b1);
    queue_op(lgs_pkg::OP_ADVANCE, 0, 1'b0);
    queue_op(lgs_pkg::OP_READ, 1, 1'b0);
    queue_op(lgs_pkg::OP_READ, 4, 1'b0);
    queue_op(lgs_pkg::OP_READ, 3, 1'b0);
    queue_op(lgs_pkg::OP_ADVANCE, 0, 1'b0);
    queue_op(lgs_pkg::OP_READ, 9, 1'b0);
    drain_block();

    // random phases; storage carries over between side settings
    for (ph = 0; ph < 15; ph++) begin
      write_grid_side(lgs_pkg::CFG_W'(side_plan[ph]));
      s = used_side(grid_side_cfg);
      steady = (ph % 4 == 2);
      queue_random_phase((s >= 16) ? 24 : 38, s >= 16);
      drain_block();
    end
    steady = 1'b0;

    $display("checked %0d results: %0d writes, %0d reads, %0d advances (%0d unchanged)",
             n_checked, n_writes, n_reads, n_advances, n_still);
    $display("%0d idle ops; grid side written %0d times, including 0, 1 and values above max",
             n_idle_ops, n_sides);
    if (fail_count == 0) begin
      $display("life_grid_generation_step_top regression: pass");
    end else begin
      $display("life_grid_generation_step_top regression: fail");
    end
    $finish;
  end

endmodule
